FILE: rtl/core/ilie_pkg.sv
// Package for the indexed list with insert and erase.
// Holds the command codes, cell control types and the element width mask.
// No dependencies.
package ilie_pkg;

    // Default number of list cells
    localparam int DEPTH_DEFAULT = 64;

    // Width of a cell position or count; covers the largest supported depth
    localparam int POS_W = 13;

    // Element and field widths
    localparam int VALUE_W = 64;
    localparam int INDEX_W = 6;
    localparam int CMD_W   = 3;
    localparam int BYTES_W = 4;

    // Element width after reset, in bytes
    localparam logic [BYTES_W-1:0] BYTES_RESET = 4'd8;

    // Number of positions that the index field can name
    localparam int INDEX_SPAN = 64;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_GET    = 3'd2,
        CMD_SET    = 3'd3,
        CMD_INSERT = 3'd4,
        CMD_ERASE  = 3'd5,
        CMD_CLEAR  = 3'd6
    } cmd_t;

    // What the cells do in a cycle
    typedef enum logic [1:0] {
        CTL_HOLD   = 2'd0,
        CTL_WRITE  = 2'd1,
        CTL_INSERT = 2'd2,
        CTL_ERASE  = 2'd3
    } ctl_kind_t;

    // Control broadcast along the row of cells
    typedef struct packed {
        ctl_kind_t          kind;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
    } cell_ctrl_t;

    // Mask for an element of the given width; 0 acts as 1 byte, above 8 as 8
    function automatic logic [VALUE_W-1:0] width_mask(input logic [BYTES_W-1:0] nbytes);
        logic [VALUE_W-1:0] m;
        if (nbytes >= 4'd8) begin
            m = {VALUE_W{1'b1}};
        end else if (nbytes == 4'd0) begin
            m = VALUE_W'(64'hFF);
        end else begin
            m = ~({VALUE_W{1'b1}} << {nbytes[2:0], 3'b000});
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/indexed_list_insert_erase.sv
// Indexed list with insert and erase: top level with control, read mux and result register.
// Depends on ilie_pkg and ilie_cell.
// Throughput: one item per cycle while the result side does not stall it through m_ready;
// every cell shifts in the same cycle, so insert and erase keep the rate of the other
// commands. The output register decouples the two sides.
// Reset (aresetn, synchronous, active low): count to zero, element width to 8 bytes,
// output empty. Cell contents are not reset.
module indexed_list_insert_erase #(
    parameter int DEPTH = ilie_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ilie_pkg::BYTES_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ilie_pkg::CMD_W-1:0]    s_command,
    input  logic [ilie_pkg::INDEX_W-1:0]  s_index,
    input  logic [ilie_pkg::VALUE_W-1:0]  s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic [ilie_pkg::VALUE_W-1:0]  m_read_value,
    output logic [$clog2(DEPTH+1)-1:0]    m_count
);
    import ilie_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RD_N  = (DEPTH < INDEX_SPAN) ? DEPTH : INDEX_SPAN;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [BYTES_W-1:0] bytes_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg;
    logic               m_ok_reg, ok_next;
    logic [VALUE_W-1:0] m_rd_reg, rd_next;
    logic [CNT_W-1:0]   m_count_reg;

    logic               accept;
    logic [POS_W-1:0]   idx_pos, cnt_pos;
    logic               in_range, full;
    logic [VALUE_W-1:0] masked_value;
    logic [VALUE_W-1:0] mux_value;
    cell_ctrl_t         ctrl;

    logic [VALUE_W-1:0] cell_q [DEPTH];

    assign accept       = s_valid && s_ready;
    assign s_ready      = !m_valid_reg || m_ready;
    assign idx_pos      = POS_W'(s_index);
    assign cnt_pos      = POS_W'(cnt_reg);
    assign in_range     = idx_pos < cnt_pos;
    assign full         = (cnt_reg == CNT_FULL);
    assign masked_value = s_value & width_mask(bytes_reg);

    // Read selection over the cells the index can reach
    always_comb begin
        mux_value = '0;
        for (int k = 0; k < RD_N; k++) begin
            if (s_index == INDEX_W'(k)) mux_value = cell_q[k];
        end
    end

    // Command decode: cell control, next count and result
    always_comb begin
        ctrl.kind  = CTL_HOLD;
        ctrl.pos   = cnt_pos;
        ctrl.value = masked_value;
        cnt_next   = cnt_reg;
        ok_next    = 1'b0;
        rd_next    = '0;
        case (s_command)
            CMD_PUSH: begin
                if (!full) begin
                    ctrl.kind = CTL_WRITE;
                    cnt_next  = cnt_reg + 1'b1;
                    ok_next   = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (!full) begin
                    if (in_range) begin
                        ctrl.kind = CTL_INSERT;
                        ctrl.pos  = idx_pos;
                    end else begin
                        ctrl.kind = CTL_WRITE;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    ok_next  = 1'b1;
                end
            end
            CMD_POP: begin
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - 1'b1;
                    ok_next  = 1'b1;
                end
            end
            CMD_GET: begin
                if (in_range) begin
                    rd_next = mux_value;
                    ok_next = 1'b1;
                end
            end
            CMD_SET: begin
                if (in_range) begin
                    ctrl.kind = CTL_WRITE;
                    ctrl.pos  = idx_pos;
                    ok_next   = 1'b1;
                end
            end
            CMD_ERASE: begin
                if (in_range) begin
                    ctrl.kind = CTL_ERASE;
                    ctrl.pos  = idx_pos;
                    cnt_next  = cnt_reg - 1'b1;
                    ok_next   = 1'b1;
                end
            end
            CMD_CLEAR: begin
                cnt_next = '0;
                ok_next  = 1'b1;
            end
            default: ;
        endcase
        // Cells only move on an accepted item
        if (!accept) ctrl.kind = CTL_HOLD;
    end

    // Row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] prev_v, next_v;
        if (g == 0) begin : g_first
            assign prev_v = cell_q[g];
        end else begin : g_mid
            assign prev_v = cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign next_v = '0;
        end else begin : g_inner
            assign next_v = cell_q[g+1];
        end
        ilie_cell #(.POS(g)) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .prev_value (prev_v),
            .next_value (next_v),
            .value      (cell_q[g])
        );
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg   <= BYTES_RESET;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) bytes_reg <= cfg_wdata;
            if (accept) begin
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_ok_reg    <= ok_next;
            m_rd_reg    <= rd_next;
            m_count_reg <= cnt_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_read_value = m_rd_reg;
    assign m_count      = m_count_reg;

    // Count never passes the depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("list count above depth");

    // Reported count matches the held count
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_count == cnt_reg))
        else $error("reported count differs from held count");

    // Clear empties the list and succeeds
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_CLEAR) |=> (cnt_reg == '0 && m_ok))
        else $error("clear did not empty the list");

    // Pop on an empty list fails and leaves the count alone
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_POP && cnt_reg == '0) |=> (!m_ok && cnt_reg == '0))
        else $error("pop on empty list misbehaved");

    // Only a successful get returns data
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command != CMD_GET) |=> (m_read_value == '0))
        else $error("read value set by a command other than get");

endmodule

FILE: rtl/core/ilie_cell.sv
// One cell of the list: holds a single element and trades it with its neighbours.
// Depends on ilie_pkg for the control struct.
module ilie_cell #(
    parameter int POS = 0
) (
    input  logic                      aclk,
    input  ilie_pkg::cell_ctrl_t      ctrl,
    input  logic [ilie_pkg::VALUE_W-1:0] prev_value,
    input  logic [ilie_pkg::VALUE_W-1:0] next_value,
    output logic [ilie_pkg::VALUE_W-1:0] value
);
    import ilie_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    // Per-cell decision: load, take from below, take from above or hold
    always_comb begin
        value_next = value_reg;
        case (ctrl.kind)
            CTL_WRITE: begin
                if (ctrl.pos == MY_POS) value_next = ctrl.value;
            end
            CTL_INSERT: begin
                if (ctrl.pos == MY_POS) begin
                    value_next = ctrl.value;
                end else if (MY_POS > ctrl.pos) begin
                    value_next = prev_value;
                end
            end
            CTL_ERASE: begin
                if (MY_POS >= ctrl.pos) value_next = next_value;
            end
            default: value_next = value_reg;
        endcase
    end

    // Payload register, no reset
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: tb/sv/tb_indexed_list_insert_erase.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_insert_erase: directed corner cases, then random
// command streams over several element widths, checked against a mirror of the list.
// Depends on ilie_pkg and the indexed_list_insert_erase top level.
module tb_indexed_list_insert_erase;
    import ilie_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 106;

    // Command code that the block does not implement
    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

    // Element width per phase, phase 0 in the low nibble
    localparam logic [N_PHASES*BYTES_W-1:0] WIDTH_PLAN = {
        4'd8, 4'd4, 4'd2, 4'd9, 4'd3, 4'd15, 4'd7, 4'd6, 4'd5, 4'd6, 4'd0, 4'd1
    };

    // Command mix of a random phase
    typedef enum int {MIX_EVEN, MIX_GROW, MIX_SHRINK} mix_t;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] rd;
        logic [CNT_W-1:0]   cnt;
    } answer_t;

    // Mirror of the list: applies each accepted command and checks the answers in order
    class list_mirror;
        logic [VALUE_W-1:0] cells [LIST_DEPTH];
        int                 held;
        logic [BYTES_W-1:0] nbytes;
        answer_t            answers_due [$];
        int                 errors;

        function new();
            held   = 0;
            nbytes = BYTES_RESET;
            errors = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function void set_width(logic [BYTES_W-1:0] b);
            nbytes = b;
        endfunction

        // 0 bytes acts as 1, anything from 8 up keeps the whole value
        function logic [VALUE_W-1:0] keep_mask();
            int b;
            b = (nbytes == '0) ? 1 : int'(nbytes);
            if (b >= 8) return ALL_ONES;
            return (64'd1 << (8 * b)) - 64'd1;
        endfunction

        function void take_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                                   logic [VALUE_W-1:0] val);
            answer_t            a;
            logic [VALUE_W-1:0] v;
            int                 pos;
            int                 k;
            v    = val & keep_mask();
            pos  = int'(idx);
            a.ok = 1'b0;
            a.rd = '0;
            case (cmd)
                CMD_PUSH, CMD_INSERT: begin
                    if (held < LIST_DEPTH) begin
                        // push, or insert at or past the end, appends
                        if (cmd == CMD_PUSH || pos >= held) pos = held;
                        for (k = held; k > pos; k--) cells[k] = cells[k-1];
                        cells[pos] = v;
                        held++;
                        a.ok = 1'b1;
                    end
                end
                CMD_POP: begin
                    if (held > 0) begin
                        held--;
                        a.ok = 1'b1;
                    end
                end
                CMD_GET: begin
                    if (pos < held) begin
                        a.rd = cells[pos];
                        a.ok = 1'b1;
                    end
                end
                CMD_SET: begin
                    if (pos < held) begin
                        cells[pos] = v;
                        a.ok = 1'b1;
                    end
                end
                CMD_ERASE: begin
                    if (pos < held) begin
                        for (k = pos; k < held - 1; k++) cells[k] = cells[k+1];
                        held--;
                        a.ok = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    held = 0;
                    a.ok = 1'b1;
                end
                default: ;
            endcase
            a.cnt = CNT_W'(held);
            answers_due.push_back(a);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_answer(logic ok, logic [VALUE_W-1:0] rd, logic [CNT_W-1:0] cnt);
            answer_t e;
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("result ok=%0b count=%0d with nothing outstanding",
                                          ok, cnt));
                return;
            end
            e = answers_due.pop_front();
            if (ok !== e.ok)
                report_mismatch($sformatf("ok %0b, expected %0b", ok, e.ok));
            if (rd !== e.rd)
                report_mismatch($sformatf("read_value %h, expected %h", rd, e.rd));
            if (cnt !== e.cnt)
                report_mismatch($sformatf("count %0d, expected %0d", cnt, e.cnt));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [BYTES_W-1:0]   cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command;
    logic [INDEX_W-1:0]   s_index;
    logic [VALUE_W-1:0]   s_value;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_ok;
    logic [VALUE_W-1:0]   m_read_value;
    logic [CNT_W-1:0]     m_count;

    bit                   idle_on;
    list_mirror           sb;

    indexed_list_insert_erase #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_index(s_index),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_ok(m_ok),
        .m_read_value(m_read_value),
        .m_count(m_count)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Sample both channels and the register port at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_answer(m_ok, m_read_value, m_count);
            if (s_valid && s_ready) sb.take_command(s_command, s_index, s_value);
            if (cfg_we) sb.set_width(cfg_wdata);
        end
    end

    // Result side: ready with random stall bursts while idling is on
    initial begin : result_sink
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                stall   = $urandom_range(1, 15) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one item, with an occasional gap first; returns at the falling edge after acceptance
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                             logic [VALUE_W-1:0] val);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_command = cmd;
        s_index   = idx;
        s_value   = val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop sending and wait for every outstanding answer
    task automatic drain_results();
        s_valid = 1'b0;
        @(posedge aclk);
        while (sb.answers_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_width(logic [BYTES_W-1:0] b);
        cfg_we    = 1'b1;
        cfg_wdata = b;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return ALL_ONES;
            1:       return '0;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin : stimulus
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] idx;
        mix_t               mix;
        int                 r;
        int                 grow;
        int                 shrink;
        sb        = new();
        aclk      = 1'b0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_command = CMD_PUSH;
        s_index   = '0;
        s_value   = '0;
        idle_on   = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty list failures, spare code, edge values, insert past end, bounds
        send_item(CMD_POP,    6'd0,  '0);
        send_item(CMD_GET,    6'd0,  '0);
        send_item(CMD_SET,    6'd0,  ALL_ONES);
        send_item(CMD_ERASE,  6'd0,  '0);
        send_item(CMD_SPARE,  6'd63, ALL_ONES);
        send_item(CMD_PUSH,   6'd0,  ALL_ONES);
        send_item(CMD_PUSH,   6'd63, '0);
        send_item(CMD_INSERT, 6'd0,  64'h0123_4567_89AB_CDEF);
        send_item(CMD_INSERT, 6'd1,  64'h8000_0000_0000_0001);
        send_item(CMD_INSERT, 6'd63, 64'hFEDC_BA98_7654_3210);
        send_item(CMD_GET,    6'd0,  '0);
        send_item(CMD_GET,    6'd4,  '0);
        send_item(CMD_GET,    6'd5,  '0);
        send_item(CMD_GET,    6'd63, ALL_ONES);
        send_item(CMD_SET,    6'd2,  64'hAAAA_AAAA_AAAA_AAAA);
        send_item(CMD_GET,    6'd2,  '0);
        send_item(CMD_ERASE,  6'd0,  '0);
        send_item(CMD_ERASE,  6'd3,  '0);
        send_item(CMD_ERASE,  6'd3,  '0);
        send_item(CMD_POP,    6'd0,  '0);
        send_item(CMD_CLEAR,  6'd0,  '0);
        send_item(CMD_GET,    6'd0,  '0);
        send_item(CMD_PUSH,   6'd0,  64'h5555_5555_5555_5555);
        send_item(CMD_POP,    6'd0,  '0);
        send_item(CMD_POP,    6'd0,  '0);

        // Random phases; the width changes between them while the list keeps its contents
        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_width(WIDTH_PLAN[p*BYTES_W +: BYTES_W]);
            idle_on = (p != 6) && (p < N_PHASES - 2);
            case (p % 6)
                0, 1:    mix = MIX_GROW;
                3, 4:    mix = MIX_SHRINK;
                default: mix = MIX_EVEN;
            endcase
            case (mix)
                MIX_GROW:   begin grow = 60; shrink = 5;  end
                MIX_SHRINK: begin grow = 10; shrink = 50; end
                default:    begin grow = 25; shrink = 25; end
            endcase
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < grow)
                    cmd = $urandom_range(0, 1) ? CMD_PUSH : CMD_INSERT;
                else if (r < grow + shrink)
                    cmd = $urandom_range(0, 1) ? CMD_POP : CMD_ERASE;
                else if (r == 97 && mix != MIX_GROW)
                    cmd = CMD_CLEAR;
                else if (r == 98)
                    cmd = CMD_SPARE;
                else
                    cmd = $urandom_range(0, 1) ? CMD_GET : CMD_SET;
                // mostly a position inside the list, sometimes anywhere
                if (sb.held > 0 && $urandom_range(0, 5) != 0)
                    idx = INDEX_W'($urandom_range(0, sb.held - 1));
                else
                    idx = INDEX_W'($urandom_range(0, 63));
                send_item(cmd, idx, random_value());
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ilie_pkg.sv
rtl/core/ilie_cell.sv
rtl/core/indexed_list_insert_erase.sv
tb/sv/tb_indexed_list_insert_erase.sv
